>>> sv/knnjw_pkg.sv
// Package for the Jaccard-weighted kNN edge scorer.
// Holds field widths, register indexes, reset values and the controller command struct.
// No dependencies.
`default_nettype none

package knnjw_pkg;

  localparam int ID_W      = 10;
  localparam int SLOT_W    = 4;
  localparam int KCFG_W    = 5;
  localparam int THR_W     = 17;
  localparam int WEIGHT_W  = 17;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  localparam logic [KCFG_W-1:0]   K_RESET   = 5'd16;
  localparam logic [THR_W-1:0]    THR_RESET = 17'd3277;
  localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOURS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_THRESHOLD  = 1'b1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic latch;
    logic rd_en;
    logic rd_row_j;
    logic clear_hit;
    logic div_init;
    logic div_step;
    logic emit;
    logic last;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/knnjw_ctrl.sv
// Controller state machine: sequences row reads, the shared-id scan, the divider and emits.
// Depends on knnjw_pkg; drives knnjw_dpath through cmd_t plus column and neighbour counters.
`default_nettype none

module knnjw_ctrl import knnjw_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 16,
  localparam int KW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          opcode_i,
  input  logic [KW-1:0] k_i,
  output logic          busy,
  output cmd_t          cmd_o,
  output logic [KW-1:0] col_o,
  output logic [KW-1:0] nbr_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROWI  = 3'd1;
  localparam logic [2:0] S_GAP   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [KW-1:0]     col_q, col_d;
  logic [KW-1:0]     nbr_q, nbr_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KW-1:0]     k_last;
  cmd_t              cmd;

  assign k_last = k_i - KW'(1);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    col_d   = col_q;
    nbr_d   = nbr_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (opcode_i == OP_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            col_d     = '0;
            state_d   = S_ROWI;
          end
        end
      end
      S_ROWI: begin
        cmd.rd_en = 1'b1;
        if (col_q == k_last) begin
          state_d = S_GAP;
        end else begin
          col_d = col_q + KW'(1);
        end
      end
      S_GAP: begin
        cmd.clear_hit = 1'b1;
        col_d         = '0;
        nbr_d         = '0;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_row_j = 1'b1;
        if (col_q == k_last) begin
          state_d = S_WAIT;
        end else begin
          col_d = col_q + KW'(1);
        end
      end
      S_WAIT: begin
        state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_d       = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_q == STEP_W'(WEIGHT_W - 1)) begin
          state_d = S_EMIT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = (nbr_q == k_last);
        if (nbr_q == k_last) begin
          state_d = S_IDLE;
        end else begin
          nbr_d         = nbr_q + KW'(1);
          col_d         = '0;
          cmd.clear_hit = 1'b1;
          state_d       = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      nbr_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      nbr_q   <= nbr_d;
      step_q  <= step_d;
    end
  end

  assign busy  = (state_q != S_IDLE);
  assign cmd_o = cmd;
  assign col_o = col_q;
  assign nbr_o = nbr_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWI || state_q == S_SCAN) |-> (col_q < k_i))
    else $error("column counter beyond K");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && nbr_q == k_last) |=> (state_q == S_IDLE))
    else $error("final edge did not return to idle");

  a_div_starts_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DINIT) |=> (state_q == S_DIV && step_q == '0))
    else $error("divider did not start at step zero");

  a_no_request_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (!cmd.wr_en && !cmd.latch))
    else $error("request taken while busy");

endmodule

`default_nettype wire

>>> sv/knnjw_dpath.sv
// Datapath: neighbour table memory, row-i buffer, shared-id counter, restoring divider,
// threshold compare and result registers. Depends on knnjw_pkg; driven by knnjw_ctrl.
`default_nettype none

module knnjw_dpath import knnjw_pkg::*; #(
  parameter int MAX_NODES      = 1024,
  parameter int MAX_NEIGHBOURS = 16,
  localparam int KW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [KW-1:0]       col_i,
  input  logic [KW-1:0]       nbr_i,
  input  logic [KW-1:0]       k_i,
  input  logic [THR_W-1:0]    thr_i,
  input  logic [ID_W-1:0]     node_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [ID_W-1:0]     neighbour_id_i,
  output logic                result_valid_o,
  output logic [ID_W-1:0]     from_node_o,
  output logic [ID_W-1:0]     to_node_o,
  output logic [WEIGHT_W-1:0] weight_o,
  output logic                kept_o,
  output logic                last_o
);

  localparam int DEPTH = MAX_NODES * MAX_NEIGHBOURS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int DW    = KW + 1;
  localparam int RW    = KW + 2;

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rd_data_q;

  logic [ID_W-1:0]           node_q;
  logic [ID_W-1:0]           rowi_q [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0] uniq_q;
  logic [MAX_NEIGHBOURS-1:0] hit_q;
  logic [MAX_NEIGHBOURS-1:0] match;

  logic          rd_vld_q, rd_j_q, rd_oor_q;
  logic [CW-1:0] rd_col_q;
  logic [KW-1:0] x_q;

  logic [RW-1:0]       rem_q;
  logic [DW-1:0]       den_q;
  logic [WEIGHT_W-1:0] quo_q;
  logic                first_q;

  logic                result_valid_q;
  logic [ID_W-1:0]     from_node_q, to_node_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                kept_q, last_q;

  logic [ID_W-1:0] rd_row;
  logic            rd_oor;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_ok;
  logic [ID_W-1:0] rd_value;
  logic            dup;
  logic [RW-1:0]   div_t;
  logic            div_ge;

  assign rd_row  = cmd_i.rd_row_j ? rowi_q[nbr_i[CW-1:0]] : node_q;
  assign rd_oor  = (32'(rd_row) >= 32'(MAX_NODES));
  assign rd_addr = AW'(32'(rd_row) * 32'(MAX_NEIGHBOURS) + 32'(col_i));
  assign wr_ok   = (32'(node_i) < 32'(MAX_NODES)) && (32'(slot_i) < 32'(MAX_NEIGHBOURS));
  assign wr_addr = AW'(32'(node_i) * 32'(MAX_NEIGHBOURS) + 32'(slot_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[wr_addr] <= neighbour_id_i;
    end
    if (cmd_i.rd_en && !rd_oor) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_j_q   <= 1'b0;
      rd_oor_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_j_q   <= cmd_i.rd_row_j;
      rd_oor_q <= rd_oor;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_col_q <= col_i[CW-1:0];
    if (cmd_i.latch) begin
      node_q <= node_i;
    end
  end

  assign rd_value = rd_oor_q ? '0 : rd_data_q;

  always_comb begin
    dup = 1'b0;
    for (int b = 0; b < MAX_NEIGHBOURS; b++) begin
      if (CW'(b) < rd_col_q && rowi_q[b] == rd_value) begin
        dup = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !rd_j_q) begin
      rowi_q[rd_col_q] <= rd_value;
      uniq_q[rd_col_q] <= !dup;
    end
  end

  always_comb begin
    for (int a = 0; a < MAX_NEIGHBOURS; a++) begin
      match[a] = rd_vld_q && rd_j_q && uniq_q[a] && (KW'(a) < k_i)
                 && (rowi_q[a] == rd_value) && !hit_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_hit) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_q | match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
    end else if (cmd_i.clear_hit) begin
      x_q <= '0;
    end else if (|match) begin
      x_q <= x_q + KW'(1);
    end
  end

  assign div_t  = first_q ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign div_ge = (div_t >= RW'(den_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q   <= RW'(x_q);
      den_q   <= {k_i, 1'b0} - DW'(x_q);
      first_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      rem_q   <= div_ge ? (div_t - RW'(den_q)) : div_t;
      quo_q   <= {quo_q[WEIGHT_W-2:0], div_ge};
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      from_node_q <= node_q;
      to_node_q   <= rowi_q[nbr_i[CW-1:0]];
      weight_q    <= quo_q;
      kept_q      <= (quo_q > thr_i);
      last_q      <= cmd_i.last;
    end
  end

  assign result_valid_o = result_valid_q;
  assign from_node_o    = from_node_q;
  assign to_node_o      = to_node_q;
  assign weight_o       = weight_q;
  assign kept_o         = kept_q;
  assign last_o         = last_q;

  a_shared_le_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> (x_q <= k_i))
    else $error("shared count exceeds K");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && rd_j_q) |-> ($countones(match) <= 1))
    else $error("neighbour id matched more than one distinct row entry");

  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> (weight_q <= ONE_Q16))
    else $error("weight above one");

endmodule

`default_nettype wire

>>> sv/knn_jaccard_edge_weights.sv
// Top level of the Jaccard-weighted kNN edge scorer: configuration registers,
// controller and datapath. Depends on knnjw_pkg, knnjw_ctrl and knnjw_dpath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  request  | start / busy               | opcode_i, node_i, slot_i, neighbour_id_i
//  result   | result_valid_o (strobe)    | from_node_o, to_node_o, weight_o, kept_o, last_o
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A load request is written while the controller stays idle; busy stays low.
// A compute request reads row i, then for each neighbour scans that neighbour's row and runs
// a 17-step restoring divider; table reads go one per cycle through the single read port.
// Results appear one at a time with last on the K-th.
// Reset is asynchronous and active low; the neighbour table is not cleared.
// The receiver cannot stall; each result strobe lasts one cycle.
`default_nettype none

module knn_jaccard_edge_weights import knnjw_pkg::*; #(
  parameter int MAX_NODES      = 1024,
  parameter int MAX_NEIGHBOURS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  logic [ID_W-1:0]      node_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [ID_W-1:0]      neighbour_id_i,
  output logic                 result_valid_o,
  output logic [ID_W-1:0]      from_node_o,
  output logic [ID_W-1:0]      to_node_o,
  output logic [WEIGHT_W-1:0]  weight_o,
  output logic                 kept_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int KW = $clog2(MAX_NEIGHBOURS + 1);

  logic [KCFG_W-1:0] k_cfg_q;
  logic [THR_W-1:0]  thr_q;
  logic [KW-1:0]     k_eff;
  cmd_t              cmd;
  logic [KW-1:0]     col;
  logic [KW-1:0]     nbr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q <= K_RESET;
      thr_q   <= THR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NEIGHBOURS_USED: k_cfg_q <= cfg_data_i[KCFG_W-1:0];
        REG_KEEP_THRESHOLD:  thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (k_cfg_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_cfg_q) > 32'(MAX_NEIGHBOURS)) begin
      k_eff = KW'(MAX_NEIGHBOURS);
    end else begin
      k_eff = KW'(k_cfg_q);
    end
  end

  knnjw_ctrl #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .k_i      (k_eff),
    .busy     (busy),
    .cmd_o    (cmd),
    .col_o    (col),
    .nbr_o    (nbr)
  );

  knnjw_dpath #(
    .MAX_NODES      (MAX_NODES),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .col_i          (col),
    .nbr_i          (nbr),
    .k_i            (k_eff),
    .thr_i          (thr_q),
    .node_i         (node_i),
    .slot_i         (slot_i),
    .neighbour_id_i (neighbour_id_i),
    .result_valid_o (result_valid_o),
    .from_node_o    (from_node_o),
    .to_node_o      (to_node_o),
    .weight_o       (weight_o),
    .kept_o         (kept_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for knn_jaccard_edge_weights: loads neighbour rows, scores edges
// and checks every edge result against an in-bench Jaccard weight predictor.
// Depends on knnjw_pkg and the knn_jaccard_edge_weights RTL.
`timescale 1ns / 1ps

module tb_top;
  import knnjw_pkg::*;

  localparam int NODES = 1024;
  localparam int SLOTS = 16;
  localparam int POOL_N = 5;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   node;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   nid;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     from_node;
    logic [ID_W-1:0]     to_node;
    logic [WEIGHT_W-1:0] weight;
    logic                kept;
    logic                last;
  } edge_rec_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode_i = OP_LOAD;
  logic [ID_W-1:0]      node_i = '0;
  logic [SLOT_W-1:0]    slot_i = '0;
  logic [ID_W-1:0]      neighbour_id_i = '0;
  logic                 result_valid_o;
  logic [ID_W-1:0]      from_node_o;
  logic [ID_W-1:0]      to_node_o;
  logic [WEIGHT_W-1:0]  weight_o;
  logic                 kept_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_NEIGHBOURS_USED;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  knn_jaccard_edge_weights i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .node_i         (node_i),
    .slot_i         (slot_i),
    .neighbour_id_i (neighbour_id_i),
    .result_valid_o (result_valid_o),
    .from_node_o    (from_node_o),
    .to_node_o      (to_node_o),
    .weight_o       (weight_o),
    .kept_o         (kept_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  logic [ID_W-1:0]   nbr_rows [NODES][SLOTS];
  logic [KCFG_W-1:0] k_cfg = K_RESET;
  logic [THR_W-1:0]  thr_cfg = THR_RESET;

  req_t        requests_pending [$];
  edge_rec_t   edges_due [$];
  req_t        next_req;
  edge_rec_t   head_edge;
  int unsigned n_pushed = 0;
  int unsigned n_taken = 0;
  int unsigned n_fail = 0;
  int unsigned gap_left = 0;
  bit          gapless = 1'b0;
  logic [ID_W-1:0] pool [POOL_N];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned shared_ids(int unsigned ri, int unsigned rj, int unsigned k);
    int unsigned x;
    bit          seen;
    bit          hit;
    x = 0;
    for (int a = 0; a < k; a++) begin
      seen = 1'b0;
      hit  = 1'b0;
      for (int b = 0; b < a; b++)
        if (nbr_rows[ri][b] == nbr_rows[ri][a]) seen = 1'b1;
      for (int b = 0; b < k; b++)
        if (nbr_rows[rj][b] == nbr_rows[ri][a]) hit = 1'b1;
      if (!seen && hit) x++;
    end
    return x;
  endfunction

  task automatic score_request(input req_t r);
    int unsigned k;
    int unsigned j;
    int unsigned x;
    int unsigned w;
    edge_rec_t   e;
    if (r.opcode == OP_LOAD) begin
      nbr_rows[r.node][r.slot] = r.nid;
    end else begin
      k = (k_cfg == 0) ? 1 : (k_cfg > SLOTS) ? SLOTS : k_cfg;
      for (int s = 0; s < k; s++) begin
        j = nbr_rows[r.node][s];
        x = shared_ids(r.node, j, k);
        w = (x << 16) / (2 * k - x);
        e.from_node = r.node;
        e.to_node   = ID_W'(j);
        e.weight    = WEIGHT_W'(w);
        e.kept      = (w > thr_cfg);
        e.last      = (s == k - 1);
        edges_due.push_back(e);
      end
    end
  endtask

  // present requests, hold while busy, idle a random gap between requests unless gapless
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        score_request('{opcode_i, node_i, slot_i, neighbour_id_i});
        n_taken++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (requests_pending.size() != 0) begin
          next_req       = requests_pending.pop_front();
          start          <= 1'b1;
          opcode_i       <= next_req.opcode;
          node_i         <= next_req.node;
          slot_i         <= next_req.slot;
          neighbour_id_i <= next_req.nid;
          gap_left       <= gapless ? 0 : $urandom_range(0, 11);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (edges_due.size() == 0) begin
        $error("unexpected result from_node=%0d to_node=%0d weight=%0d",
               from_node_o, to_node_o, weight_o);
        n_fail++;
      end else begin
        head_edge = edges_due.pop_front();
        check_field("from_node", head_edge.from_node, from_node_o);
        check_field("to_node", head_edge.to_node, to_node_o);
        check_field("weight", head_edge.weight, weight_o);
        check_field("kept", head_edge.kept, kept_o);
        check_field("last", head_edge.last, last_o);
      end
    end
  end

  task automatic queue_request(input logic op, input logic [ID_W-1:0] node,
                               input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] nid);
    requests_pending.push_back('{op, node, slot, nid});
    n_pushed++;
  endtask

  task automatic wait_drained(input int unsigned settle);
    do @(posedge clk_i);
    while (n_taken != n_pushed || start || busy || edges_due.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_NEIGHBOURS_USED) k_cfg = data[KCFG_W-1:0];
    else thr_cfg = data[THR_W-1:0];
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    return pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  initial begin
    bit fresh;
    pool[0] = 10'd0;
    pool[1] = 10'd1023;
    pool[2] = 10'd341;
    pool[3] = 10'd682;
    for (int p = 4; p < POOL_N; p++) begin
      do begin
        pool[p] = ID_W'($urandom_range(1, 1022));
        fresh = 1'b1;
        for (int q = 0; q < p; q++)
          if (pool[q] == pool[p]) fresh = 1'b0;
      end while (!fresh);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every pool row with random pool ids
    gapless = 1'b1;
    for (int p = 0; p < POOL_N; p++)
      for (int s = 0; s < SLOTS; s++)
        queue_request(OP_LOAD, pool[p], SLOT_W'(s), pick_id());
    gapless = 1'b0;

    queue_request(OP_COMPUTE, 10'd1023, '0, '0);
    queue_request(OP_LOAD, 10'd0, 4'd0, 10'd0);
    queue_request(OP_LOAD, 10'd0, 4'd15, 10'd1023);
    queue_request(OP_COMPUTE, 10'd0, 4'd15, 10'd1023);
    wait_drained(8);

    write_reg(REG_NEIGHBOURS_USED, 17'd1);
    write_reg(REG_KEEP_THRESHOLD, 17'd0);
    queue_request(OP_COMPUTE, 10'd0, '0, '0);
    queue_request(OP_COMPUTE, 10'd341, '0, '0);
    queue_request(OP_COMPUTE, 10'd682, '0, '0);
    wait_drained(8);

    write_reg(REG_NEIGHBOURS_USED, 17'd0);
    write_reg(REG_KEEP_THRESHOLD, 17'd65536);
    queue_request(OP_COMPUTE, 10'd0, '0, '0);
    queue_request(OP_COMPUTE, 10'd1023, '0, '0);
    wait_drained(8);

    write_reg(REG_NEIGHBOURS_USED, 17'h1FFFF);
    write_reg(REG_KEEP_THRESHOLD, 17'h1FFFF);
    queue_request(OP_COMPUTE, 10'd341, '0, '0);
    queue_request(OP_COMPUTE, 10'd0, '0, '0);
    wait_drained(8);

    write_reg(REG_NEIGHBOURS_USED, 17'd16);
    write_reg(REG_KEEP_THRESHOLD, 17'd65535);
    queue_request(OP_COMPUTE, 10'd0, '0, '0);
    queue_request(OP_COMPUTE, 10'd682, '0, '0);
    wait_drained(8);

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_NEIGHBOURS_USED, 17'($urandom_range(1, 16)));
      write_reg(REG_KEEP_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                17'($urandom_range(0, 65536)) : 17'($urandom_range(0, 8000)));
      gapless = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 6; n++) begin
        if ($urandom_range(0, 99) < 35)
          queue_request(OP_LOAD, pick_id(), SLOT_W'($urandom_range(0, 15)), pick_id());
        else
          queue_request(OP_COMPUTE, pick_id(), SLOT_W'($urandom), ID_W'($urandom));
      end
      wait_drained(8);
    end

    wait_drained(700);
    if (n_fail == 0)
      $display("[knn_jaccard_edge_weights] OK");
    else
      $display("[knn_jaccard_edge_weights] ERROR");
    $finish;
  end

  initial begin
    #1500000;
    $display("[knn_jaccard_edge_weights] ERROR");
    $finish;
  end

endmodule
